FILE: src/tch_pkg.sv
// Shared constants for the tilt compensated heading core.
`timescale 1ns / 1ps
`default_nettype none

package tch_pkg;

    // Upper bound on CORDIC iterations (size of the arctangent table)
    localparam int MAX_STAGES = 24;

    // Angle word: Q3.28 radians, 33 bits signed
    localparam int ZW = 33;

    // arctan(2^-i) in Q3.28, rounded to nearest
    localparam logic signed [ZW-1:0] ATAN_Q28 [MAX_STAGES] = '{
        33'sd210828714, 33'sd124459457, 33'sd65760959, 33'sd33381290,
        33'sd16755422,  33'sd8385879,   33'sd4193963,  33'sd2097109,
        33'sd1048571,   33'sd524287,    33'sd262144,   33'sd131072,
        33'sd65536,     33'sd32768,     33'sd16384,    33'sd8192,
        33'sd4096,      33'sd2048,      33'sd1024,     33'sd512,
        33'sd256,       33'sd128,       33'sd64,       33'sd32
    };

    localparam logic signed [ZW-1:0] PI_Q28      = 33'sd843314857;
    localparam logic signed [ZW-1:0] HALF_PI_Q28 = 33'sd421657428;

    // 1/K of the CORDIC gain in Q30, start value for sine/cosine rotation
    localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032874;

    // Radians Q28 to degrees Q7: multiply, then shift right by 44
    localparam logic [28:0] DEG_MUL = 29'd480631834;

    // 360 degrees with 7 fraction bits
    localparam logic signed [19:0] FULL_TURN = 20'sd46080;

endpackage

`default_nettype wire

FILE: src/tilt_compensated_heading_core.sv
// Top level: pipelined tilt compensated compass heading.
`timescale 1ns / 1ps
`default_nettype none

// Takes one magnetometer beat (X, Y, Z counts plus pitch and roll in Q3.13
// radians) per cycle while in_stall is low and returns one heading beat in
// degrees Q9.7, wrapped to [0, 360), with heading_valid low (heading 0) when
// the field magnitude is below min_field_norm. Throughput is one beat per clock
// unless out_stall holds the output beat. The two CORDIC chains (sine/cosine
// rotation and atan2 vectoring) run one iteration per register stage. The whole
// pipeline advances together: in_stall is high exactly when the output beat
// is held by out_stall. min_field_norm is written through cfg_valid/cfg_data
// (always ready) and should only change while the pipeline is empty.
module tilt_compensated_heading_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data,
    // input beat
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] field_x,
    input  wire logic signed [15:0] field_y,
    input  wire logic signed [15:0] field_z,
    input  wire logic signed [15:0] pitch_angle,
    input  wire logic signed [15:0] roll_angle,
    // output beat
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [15:0]             heading,
    output logic                    heading_valid
);

    localparam int NS  = (CORDIC_STAGES < tch_pkg::MAX_STAGES) ?
                         CORDIC_STAGES : tch_pkg::MAX_STAGES;
    localparam int LAT = 2 * NS + 10;
    localparam int ZW  = tch_pkg::ZW;
    localparam int RW  = 34;   // sine/cosine rotation datapath
    localparam int CW  = 56;   // compensated components
    localparam int VW  = 58;   // vectoring datapath

    // ---------------- control ----------------
    logic           adv;
    logic [LAT-1:0] vld_reg;
    logic [15:0]    norm_reg;
    logic [31:0]    norm_sq_reg;

    assign adv       = !vld_reg[LAT-1] || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;
    assign out_valid = vld_reg[LAT-1];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // threshold register and its square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_reg    <= 16'd1;
            norm_sq_reg <= 32'd1;
        end
        else
        begin
            if (cfg_valid)
                norm_reg <= cfg_data;
            norm_sq_reg <= norm_reg * norm_reg;
        end
    end

    // ---------------- S0: input capture ----------------
    logic signed [16:0] mx0_reg, my0_reg, mz0_reg;
    logic signed [15:0] pa0_reg, ra0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx0_reg <= -17'(field_x);
            my0_reg <= 17'(field_y);
            mz0_reg <= 17'(field_z);
            pa0_reg <= pitch_angle;
            ra0_reg <= roll_angle;
        end
    end

    // ---------------- S1: squares, angle fold ----------------
    logic [31:0]          sqx1_reg, sqy1_reg, sqz1_reg;
    logic signed [16:0]   mx1_reg, my1_reg, mz1_reg;
    logic signed [ZW-1:0] pz1_reg, rz1_reg;
    logic                 pf1_reg, rf1_reg;
    logic signed [ZW-1:0] pz_raw, rz_raw;

    assign pz_raw = {{2{pa0_reg[15]}}, pa0_reg, 15'b0};
    assign rz_raw = {{2{ra0_reg[15]}}, ra0_reg, 15'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx1_reg <= 32'(mx0_reg * mx0_reg);
            sqy1_reg <= 32'(my0_reg * my0_reg);
            sqz1_reg <= 32'(mz0_reg * mz0_reg);
            mx1_reg  <= mx0_reg;
            my1_reg  <= my0_reg;
            mz1_reg  <= mz0_reg;
            // fold by pi outside +-pi/2, flipping the signs at the end
            if (pz_raw > tch_pkg::HALF_PI_Q28)
            begin
                pz1_reg <= pz_raw - tch_pkg::PI_Q28;
                pf1_reg <= 1'b1;
            end
            else if (pz_raw < -tch_pkg::HALF_PI_Q28)
            begin
                pz1_reg <= pz_raw + tch_pkg::PI_Q28;
                pf1_reg <= 1'b1;
            end
            else
            begin
                pz1_reg <= pz_raw;
                pf1_reg <= 1'b0;
            end
            if (rz_raw > tch_pkg::HALF_PI_Q28)
            begin
                rz1_reg <= rz_raw - tch_pkg::PI_Q28;
                rf1_reg <= 1'b1;
            end
            else if (rz_raw < -tch_pkg::HALF_PI_Q28)
            begin
                rz1_reg <= rz_raw + tch_pkg::PI_Q28;
                rf1_reg <= 1'b1;
            end
            else
            begin
                rz1_reg <= rz_raw;
                rf1_reg <= 1'b0;
            end
        end
    end

    // ---------------- rotation CORDIC: sine/cosine of pitch and roll ----------------
    logic signed [RW-1:0] px_reg [NS];
    logic signed [RW-1:0] py_reg [NS];
    logic signed [ZW-1:0] pz_reg [NS];
    logic signed [RW-1:0] qx_reg [NS];
    logic signed [RW-1:0] qy_reg [NS];
    logic signed [ZW-1:0] qz_reg [NS];
    logic signed [16:0]   cmx_reg [NS];
    logic signed [16:0]   cmy_reg [NS];
    logic signed [16:0]   cmz_reg [NS];
    logic                 cpf_reg [NS];
    logic                 crf_reg [NS];
    logic                 cok_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_rot
        logic signed [RW-1:0] px_i, py_i, qx_i, qy_i;
        logic signed [ZW-1:0] pz_i, qz_i;
        logic signed [16:0]   mx_i, my_i, mz_i;
        logic                 pf_i, rf_i, ok_i;

        if (k == 0)
        begin : g_first
            logic [33:0] sq_sum;
            assign sq_sum = 34'(sqx1_reg) + 34'(sqy1_reg) + 34'(sqz1_reg);
            assign px_i = tch_pkg::GAIN_INV_Q30;
            assign py_i = '0;
            assign pz_i = pz1_reg;
            assign qx_i = tch_pkg::GAIN_INV_Q30;
            assign qy_i = '0;
            assign qz_i = rz1_reg;
            assign mx_i = mx1_reg;
            assign my_i = my1_reg;
            assign mz_i = mz1_reg;
            assign pf_i = pf1_reg;
            assign rf_i = rf1_reg;
            assign ok_i = (sq_sum >= 34'(norm_sq_reg));
        end
        else
        begin : g_next
            assign px_i = px_reg[k-1];
            assign py_i = py_reg[k-1];
            assign pz_i = pz_reg[k-1];
            assign qx_i = qx_reg[k-1];
            assign qy_i = qy_reg[k-1];
            assign qz_i = qz_reg[k-1];
            assign mx_i = cmx_reg[k-1];
            assign my_i = cmy_reg[k-1];
            assign mz_i = cmz_reg[k-1];
            assign pf_i = cpf_reg[k-1];
            assign rf_i = crf_reg[k-1];
            assign ok_i = cok_reg[k-1];
        end

        // one micro-rotation per stage for each angle
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (pz_i >= 0)
                begin
                    px_reg[k] <= px_i - (py_i >>> k);
                    py_reg[k] <= py_i + (px_i >>> k);
                    pz_reg[k] <= pz_i - tch_pkg::ATAN_Q28[k];
                end
                else
                begin
                    px_reg[k] <= px_i + (py_i >>> k);
                    py_reg[k] <= py_i - (px_i >>> k);
                    pz_reg[k] <= pz_i + tch_pkg::ATAN_Q28[k];
                end
                if (qz_i >= 0)
                begin
                    qx_reg[k] <= qx_i - (qy_i >>> k);
                    qy_reg[k] <= qy_i + (qx_i >>> k);
                    qz_reg[k] <= qz_i - tch_pkg::ATAN_Q28[k];
                end
                else
                begin
                    qx_reg[k] <= qx_i + (qy_i >>> k);
                    qy_reg[k] <= qy_i - (qx_i >>> k);
                    qz_reg[k] <= qz_i + tch_pkg::ATAN_Q28[k];
                end
                cmx_reg[k] <= mx_i;
                cmy_reg[k] <= my_i;
                cmz_reg[k] <= mz_i;
                cpf_reg[k] <= pf_i;
                crf_reg[k] <= rf_i;
                cok_reg[k] <= ok_i;
            end
        end
    end

    // ---------------- R: round to Q15, undo fold ----------------
    logic signed [RW-1:0] cp_rnd, sp_rnd, cr_rnd, sr_rnd;
    logic signed [17:0]   cp_q, sp_q, cr_q, sr_q;
    logic signed [17:0]   cp_reg, sp_reg, cr_reg, sr_reg;
    logic signed [16:0]   mxr_reg, myr_reg, mzr_reg;
    logic                 okr_reg;

    assign cp_rnd = px_reg[NS-1] + RW'(16384);
    assign sp_rnd = py_reg[NS-1] + RW'(16384);
    assign cr_rnd = qx_reg[NS-1] + RW'(16384);
    assign sr_rnd = qy_reg[NS-1] + RW'(16384);
    assign cp_q   = cp_rnd[32:15];
    assign sp_q   = sp_rnd[32:15];
    assign cr_q   = cr_rnd[32:15];
    assign sr_q   = sr_rnd[32:15];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cp_reg  <= cpf_reg[NS-1] ? -cp_q : cp_q;
            sp_reg  <= cpf_reg[NS-1] ? -sp_q : sp_q;
            cr_reg  <= crf_reg[NS-1] ? -cr_q : cr_q;
            sr_reg  <= crf_reg[NS-1] ? -sr_q : sr_q;
            mxr_reg <= cmx_reg[NS-1];
            myr_reg <= cmy_reg[NS-1];
            mzr_reg <= cmz_reg[NS-1];
            okr_reg <= cok_reg[NS-1];
        end
    end

    // ---------------- M1: first products ----------------
    logic signed [34:0] p_mxcp_reg, p_mzsp_reg, p_mxsp_reg, p_mycr_reg, p_mzcp_reg;
    logic signed [17:0] srm1_reg;
    logic               okm1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_mxcp_reg <= mxr_reg * cp_reg;
            p_mzsp_reg <= mzr_reg * sp_reg;
            p_mxsp_reg <= mxr_reg * sp_reg;
            p_mycr_reg <= myr_reg * cr_reg;
            p_mzcp_reg <= mzr_reg * cp_reg;
            srm1_reg   <= sr_reg;
            okm1_reg   <= okr_reg;
        end
    end

    // ---------------- M2: X component, products with sin(roll) ----------------
    logic signed [CW-1:0] cx2_reg, myc2_reg;
    logic signed [52:0]   q_a2_reg, q_b2_reg;
    logic                 okm2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx2_reg  <= (CW'(p_mxcp_reg) + CW'(p_mzsp_reg)) <<< 15;
            myc2_reg <= CW'(p_mycr_reg) <<< 15;
            q_a2_reg <= p_mxsp_reg * srm1_reg;
            q_b2_reg <= p_mzcp_reg * srm1_reg;
            okm2_reg <= okm1_reg;
        end
    end

    // ---------------- M3: Y component ----------------
    logic signed [CW-1:0] cx3_reg, cy3_reg;
    logic                 okm3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx3_reg  <= cx2_reg;
            cy3_reg  <= CW'(q_a2_reg) + myc2_reg - CW'(q_b2_reg);
            okm3_reg <= okm2_reg;
        end
    end

    // ---------------- V0: move vector into right half plane ----------------
    logic signed [VW-1:0] vx0_reg, vy0_reg;
    logic signed [ZW-1:0] vz0_reg;
    logic                 vok0_reg, vzero0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (cx3_reg < 0)
            begin
                vx0_reg <= -VW'(cx3_reg);
                vy0_reg <= -VW'(cy3_reg);
                vz0_reg <= tch_pkg::PI_Q28;
            end
            else
            begin
                vx0_reg <= VW'(cx3_reg);
                vy0_reg <= VW'(cy3_reg);
                vz0_reg <= '0;
            end
            vok0_reg   <= okm3_reg;
            vzero0_reg <= (cx3_reg == '0) && (cy3_reg == '0);
        end
    end

    // ---------------- vectoring CORDIC: atan2 ----------------
    logic signed [VW-1:0] vx_reg [NS];
    logic signed [VW-1:0] vy_reg [NS];
    logic signed [ZW-1:0] vz_reg [NS];
    logic                 vok_reg [NS];
    logic                 vzero_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_vec
        logic signed [VW-1:0] x_i, y_i;
        logic signed [ZW-1:0] z_i;
        logic                 ok_i, zero_i;

        if (k == 0)
        begin : g_first
            assign x_i    = vx0_reg;
            assign y_i    = vy0_reg;
            assign z_i    = vz0_reg;
            assign ok_i   = vok0_reg;
            assign zero_i = vzero0_reg;
        end
        else
        begin : g_next
            assign x_i    = vx_reg[k-1];
            assign y_i    = vy_reg[k-1];
            assign z_i    = vz_reg[k-1];
            assign ok_i   = vok_reg[k-1];
            assign zero_i = vzero_reg[k-1];
        end

        // drive y toward zero, accumulating the angle
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (y_i > 0)
                begin
                    vx_reg[k] <= x_i + (y_i >>> k);
                    vy_reg[k] <= y_i - (x_i >>> k);
                    vz_reg[k] <= z_i + tch_pkg::ATAN_Q28[k];
                end
                else
                begin
                    vx_reg[k] <= x_i - (y_i >>> k);
                    vy_reg[k] <= y_i + (x_i >>> k);
                    vz_reg[k] <= z_i - tch_pkg::ATAN_Q28[k];
                end
                vok_reg[k]   <= ok_i;
                vzero_reg[k] <= zero_i;
            end
        end
    end

    // ---------------- D1: degree conversion partial products ----------------
    logic signed [16:0] z_hi;
    logic [15:0]        z_lo;
    logic signed [46:0] dp_hi_reg;
    logic [44:0]        dp_lo_reg;
    logic               dok_reg, dzero_reg;

    assign z_hi = vz_reg[NS-1][32:16];
    assign z_lo = vz_reg[NS-1][15:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dp_hi_reg <= z_hi * $signed({1'b0, tch_pkg::DEG_MUL});
            dp_lo_reg <= z_lo * tch_pkg::DEG_MUL;
            dok_reg   <= vok_reg[NS-1];
            dzero_reg <= vzero_reg[NS-1];
        end
    end

    // ---------------- D2: sum, round, shift ----------------
    logic [63:0]        dsum;
    logic signed [19:0] deg_reg;
    logic               eok_reg, ezero_reg;

    assign dsum = (64'(dp_hi_reg) <<< 16) + {19'b0, dp_lo_reg} + 64'h0000_0800_0000_0000;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg_reg   <= dsum[63:44];
            eok_reg   <= dok_reg;
            ezero_reg <= dzero_reg;
        end
    end

    // ---------------- OUT: wrap into one turn, output register ----------------
    logic signed [19:0] w_a, w_b, w_c, w_d;
    logic [15:0]        heading_reg;
    logic               heading_valid_reg;

    always_comb
    begin
        w_a = (deg_reg < 0) ? deg_reg + tch_pkg::FULL_TURN : deg_reg;
        w_b = (w_a < 0) ? '0 : w_a;
        w_c = (w_b >= tch_pkg::FULL_TURN) ? w_b - tch_pkg::FULL_TURN : w_b;
        w_d = (w_c >= tch_pkg::FULL_TURN) ? '0 : w_c;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            heading_reg       <= (eok_reg && !ezero_reg) ? w_d[15:0] : 16'd0;
            heading_valid_reg <= eok_reg;
        end
    end

    assign heading       = heading_reg;
    assign heading_valid = heading_valid_reg;

    // ---------------- assertions ----------------
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !heading_valid |-> heading == 16'd0)
        else $error("invalid heading beat carries nonzero heading");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading < 16'd46080)
        else $error("heading outside one turn");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall not tied to held output beat");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted beat lost at pipeline entry");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench for the tilt compensated heading core: random beats checked against a predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int STAGES   = 16;
    localparam int LATENCY  = 2 * STAGES + 10;
    localparam int ITEMS    = 1000;

    typedef struct {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } sample_t;

    typedef struct {
        logic [15:0] heading;
        logic        valid;
    } heading_t;

    // Expected headings and the compass predictor behind them
    class heading_board;
        heading_t    pending[$];
        logic [15:0] norm_limit;
        int          errors;

        function new();
            norm_limit = 16'd1;
            errors     = 0;
        endfunction

        // CORDIC rotation: sine and cosine of a Q3.13 angle, in Q15
        function void rotate(input longint ang, output longint s, output longint c);
            longint z, x, y, dx, dy;
            bit     flip;
            z = ang * 32768;
            x = longint'(tch_pkg::GAIN_INV_Q30);
            y = 0;
            flip = 0;
            if (z > longint'(tch_pkg::HALF_PI_Q28))
            begin
                z -= longint'(tch_pkg::PI_Q28);
                flip = 1;
            end
            else if (z < -longint'(tch_pkg::HALF_PI_Q28))
            begin
                z += longint'(tch_pkg::PI_Q28);
                flip = 1;
            end
            for (int i = 0; i < STAGES && i < tch_pkg::MAX_STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= longint'(tch_pkg::ATAN_Q28[i]);
                end
                else
                begin
                    x += dx; y -= dy; z += longint'(tch_pkg::ATAN_Q28[i]);
                end
            end
            x = (x + 16384) >>> 15;
            y = (y + 16384) >>> 15;
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        // CORDIC vectoring: angle of (x, y) in Q3.28
        function longint bearing(input longint x, input longint y);
            longint z, dx, dy;
            z = 0;
            if (x < 0)
            begin
                x = -x; y = -y; z = longint'(tch_pkg::PI_Q28);
            end
            for (int i = 0; i < STAGES && i < tch_pkg::MAX_STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x += dx; y -= dy; z += longint'(tch_pkg::ATAN_Q28[i]);
                end
                else
                begin
                    x -= dx; y += dy; z -= longint'(tch_pkg::ATAN_Q28[i]);
                end
            end
            return z;
        endfunction

        function heading_t compass(input sample_t s);
            heading_t r;
            longint mx, my, mz, sq, lim, sp, cp, sr, cr, cx, cy, d;
            mx = -longint'(s.fx);
            my = longint'(s.fy);
            mz = longint'(s.fz);
            sq = mx * mx + my * my + mz * mz;
            lim = longint'(norm_limit) * longint'(norm_limit);
            r.heading = '0;
            r.valid   = 1'b0;
            if (sq < lim)
                return r;
            rotate(longint'(s.pitch), sp, cp);
            rotate(longint'(s.roll), sr, cr);
            cx = (mx * cp + mz * sp) * 32768;
            cy = mx * sp * sr + my * cr * 32768 - mz * cp * sr;
            r.valid = 1'b1;
            if (cx == 0 && cy == 0)
                return r;
            d = (bearing(cx, cy) * longint'(tch_pkg::DEG_MUL) + (longint'(1) <<< 43)) >>> 44;
            if (d < 0) d += longint'(tch_pkg::FULL_TURN);
            if (d < 0) d = 0;
            if (d >= longint'(tch_pkg::FULL_TURN)) d -= longint'(tch_pkg::FULL_TURN);
            if (d >= longint'(tch_pkg::FULL_TURN)) d = 0;
            r.heading = d[15:0];
            return r;
        endfunction

        function void note_sample(input sample_t s);
            pending.push_back(compass(s));
        endfunction

        function void check_heading(input logic [15:0] hdg, input logic vld);
            heading_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected heading beat: heading=%0d valid=%0b", hdg, vld);
                return;
            end
            e = pending.pop_front();
            if (hdg !== e.heading || vld !== e.valid)
            begin
                errors++;
                if (errors <= 10)
                    $display("heading mismatch: expected %0d/%0b, got %0d/%0b",
                             e.heading, e.valid, hdg, vld);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] field_x, field_y, field_z, pitch_angle, roll_angle;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        heading;
    logic               heading_valid;

    heading_board board;
    bit           long_hold;
    bit           quiet_rx;
    bit           stim_done;

    tilt_compensated_heading_core #(.CORDIC_STAGES(STAGES)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .field_x      (field_x),
        .field_y      (field_y),
        .field_z      (field_z),
        .pitch_angle  (pitch_angle),
        .roll_angle   (roll_angle),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .heading      (heading),
        .heading_valid(heading_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sample both channels mid-cycle, where inputs and outputs are settled
    always @(negedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_sample('{field_x, field_y, field_z, pitch_angle, roll_angle});
        if (rst_n && out_valid && !out_stall)
            board.check_heading(heading, heading_valid);
    end

    // Receiver: random stall per beat, plus one long hold-off on request
    initial
    begin
        int  n;
        bit  took;
        bit  hold_done;
        hold_done = 0;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (long_hold && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_done = 1;
            end
            n = quiet_rx ? 0 : $urandom_range(0, 19);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                took = out_valid && !out_stall;
                @(posedge clk);
            end while (!took && !(long_hold && !hold_done));
        end
    end

    // One input beat after a random gap (none when no_gap is set); holds until accepted
    task automatic send_sample(input sample_t s, input bit no_gap);
        int n;
        bit took;
        n = no_gap ? 0 : $urandom_range(0, 19);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid    <= 1'b1;
        field_x     <= s.fx;
        field_y     <= s.fy;
        field_z     <= s.fz;
        pitch_angle <= s.pitch;
        roll_angle  <= s.roll;
        do
        begin
            @(negedge clk);
            took = in_valid && !in_stall;
            @(posedge clk);
        end while (!took);
    endtask

    // Wait for the pipeline to drain, with no new input beats
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_norm_limit(input logic [15:0] v);
        bit took;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(negedge clk);
            took = cfg_valid && cfg_ready;
            @(posedge clk);
        end while (!took);
        cfg_valid <= 1'b0;
        board.norm_limit = v;
    endtask

    function automatic logic signed [15:0] rand_angle();
        return 16'($signed($urandom_range(0, 51472)) - 25736);
    endfunction

    // Random sample; field scale picked so some land near the threshold
    function automatic sample_t rand_sample(input logic [15:0] lim);
        sample_t s;
        int      span;
        case ($urandom_range(0, 3))
            0:       span = 32767;
            1:       span = (lim < 2) ? 4 : int'(lim);
            2:       span = 300;
            default: span = (lim < 2) ? 2 : int'(lim) / 2 + 1;
        endcase
        if (span > 32767) span = 32767;
        if (span == 32767 && $urandom_range(0, 1))
        begin
            s.fx = 16'($urandom);
            s.fy = 16'($urandom);
            s.fz = 16'($urandom);
        end
        else
        begin
            s.fx = 16'($signed($urandom_range(0, 2 * span)) - span);
            s.fy = 16'($signed($urandom_range(0, 2 * span)) - span);
            s.fz = 16'($signed($urandom_range(0, 2 * span)) - span);
        end
        s.pitch = rand_angle();
        s.roll  = rand_angle();
        return s;
    endfunction

    sample_t     directed[$];
    logic [15:0] limits[6];

    initial
    begin
        sample_t s;
        bit      burst;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        field_x     = '0;
        field_y     = '0;
        field_z     = '0;
        pitch_angle = '0;
        roll_angle  = '0;
        long_hold   = 0;
        quiet_rx    = 0;
        stim_done   = 0;
        board       = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero field, zero horizontal vector, extremes, quarter turns
        directed = '{
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
            '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd5000, 16'sd0, 16'sd0},
            '{-16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
            '{16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd1000, 16'sd0, 16'sd0, 16'sd0},
            '{16'sd0, -16'sd1000, 16'sd0, 16'sd0, 16'sd0},
            '{-16'sd1000, -16'sd1, 16'sd0, 16'sd0, 16'sd0},
            '{-16'sd1000, 16'sd1, 16'sd0, 16'sd0, 16'sd0},
            '{-16'sh8000, -16'sh8000, -16'sh8000, 16'sd25736, 16'sd25736},
            '{16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sd25736, -16'sd25736},
            '{-16'sh8000, 16'sh7fff, -16'sh8000, -16'sd25736, 16'sd25736},
            '{16'sd1200, -16'sd800, 16'sd300, 16'sd12868, 16'sd0},
            '{16'sd1200, -16'sd800, 16'sd300, -16'sd12868, 16'sd12868},
            '{16'sd1200, -16'sd800, 16'sd300, 16'sd0, -16'sd12869},
            '{16'sd500, 16'sd500, 16'sd500, 16'sd25735, -16'sd25735},
            '{-16'sd7, 16'sd3, 16'sd9, 16'sd100, -16'sd100}
        };
        foreach (directed[i])
            send_sample(directed[i], 1'b0);
        drain();

        limits = '{16'd1, 16'd0, 16'hffff, 16'd1000, 16'($urandom), 16'd1};
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
                write_norm_limit(limits[p]);
            if (p == 2)
                send_sample('{-16'sh8000, -16'sh8000, -16'sh8000, 16'sd0, 16'sd0}, 1'b0);
            quiet_rx = (p == 4);
            for (int k = 0; k < ITEMS / 6; k++)
            begin
                // Long receiver hold-off with the sender pushing back-to-back
                if (p == 3 && k == 20)
                    long_hold = 1;
                burst = (p == 3 && k >= 20 && k < 120) || (p == 4);
                s = rand_sample(limits[p]);
                send_sample(s, burst);
            end
            drain();
        end
        stim_done = 1;
    end

    // End of run: wait for the stimulus to finish and the pipeline to empty
    initial
    begin
        @(posedge rst_n);
        wait (stim_done === 1'b1);
        repeat (LATENCY + 20) @(posedge clk);
        if (board.pending.size() != 0)
            board.errors += board.pending.size();
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: tilt_compensated_heading_core.f
src/tch_pkg.sv
src/tilt_compensated_heading_core.sv
tb/sv/testbench.sv
